### rtl/core/int8_dot_product_scale_unit_assert.svh
// Assertion macros shared by the dot product and scale unit.
`ifndef INT8_DOT_PRODUCT_SCALE_UNIT_ASSERT_SVH
`define INT8_DOT_PRODUCT_SCALE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define I8DPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define I8DPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define I8DPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define I8DPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/i8dps_pkg.sv
// Shared types and constants for the int8 dot product and scale unit.
package i8dps_pkg;

    localparam int LANES      = 4;
    localparam int PHYS_LANES = 4;
    localparam int LANE_LIM   = (LANES < PHYS_LANES) ? LANES : PHYS_LANES;
    localparam int CNT_W      = 3;
    localparam int ACT_W      = 8;
    localparam int PROD_W     = 2 * ACT_W;
    localparam int SUM_W      = PROD_W + $clog2(PHYS_LANES + 1);
    localparam int ACC_W      = 32;
    localparam int SCALE_W    = 32;
    localparam int OUT_W      = ACC_W + SCALE_W;

    typedef struct packed {
        logic signed [ACT_W-1:0]   act0;
        logic signed [ACT_W-1:0]   act1;
        logic signed [ACT_W-1:0]   act2;
        logic signed [ACT_W-1:0]   act3;
        logic signed [ACT_W-1:0]   wgt0;
        logic signed [ACT_W-1:0]   wgt1;
        logic signed [ACT_W-1:0]   wgt2;
        logic signed [ACT_W-1:0]   wgt3;
        logic [CNT_W-1:0]          lane_count;
        logic signed [SCALE_W-1:0] col_scale;
        logic                      last;
    } t_in_word;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot_sum;
        logic signed [OUT_W-1:0] scaled_value;
    } t_out_word;

    typedef logic [PHYS_LANES-1:0][PROD_W-1:0] t_prod_vec;

    typedef struct packed {
        logic vld;
        logic last;
    } t_stage_ctl;

    typedef struct packed {
        logic signed [ACC_W-1:0]   dot;
        logic signed [SCALE_W-1:0] scale;
    } t_sum_word;

endpackage

### rtl/core/i8dps_lane.sv
// One multiplier lane: registered signed int8 product, zero when the lane is unused.
module i8dps_lane (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic                                 i_en,
    input  logic signed [i8dps_pkg::ACT_W-1:0]   i_act,
    input  logic signed [i8dps_pkg::ACT_W-1:0]   i_wgt,
    output logic signed [i8dps_pkg::PROD_W-1:0]  o_prod
);
    import i8dps_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    assign w_prod = i_act * i_wgt;
    assign n_prod = i_en ? w_prod : '0;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/i8dps_merge.sv
// Merging stage: adds the lane products into the wrapping accumulator and holds a finished sum.
`include "int8_dot_product_scale_unit_assert.svh"

module i8dps_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  i8dps_pkg::t_stage_ctl        i_ctl,
    input  i8dps_pkg::t_prod_vec         i_prods,
    input  logic signed [i8dps_pkg::SCALE_W-1:0] i_scale,
    input  logic                         i_take,
    output logic                         o_adv,
    output logic                         o_sum_vld,
    output i8dps_pkg::t_sum_word         o_sum_word
);
    import i8dps_pkg::*;

    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         n_acc;
    logic                     r_sum_vld;
    logic                     n_sum_vld;
    t_sum_word                r_sum_word;
    logic signed [SUM_W-1:0]  w_tree;
    logic [ACC_W-1:0]         w_total;
    logic                     w_free;

    always_comb begin
        w_tree = '0;
        for (int i = 0; i < PHYS_LANES; i++) begin
            w_tree = w_tree + SUM_W'($signed(i_prods[i]));
        end
    end

    assign w_total = r_acc + ACC_W'(w_tree);
    assign w_free  = !r_sum_vld || i_take;
    assign o_adv   = i_ctl.vld && (!i_ctl.last || w_free);

    always_comb begin
        n_acc     = r_acc;
        n_sum_vld = r_sum_vld && !i_take;
        if (o_adv) begin
            if (i_ctl.last) begin
                n_acc     = '0;
                n_sum_vld = 1'b1;
            end else begin
                n_acc = w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_sum_vld <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_sum_vld <= n_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_ctl.last) begin
            r_sum_word.dot   <= w_total;
            r_sum_word.scale <= i_scale;
        end
    end

    assign o_sum_vld  = r_sum_vld;
    assign o_sum_word = r_sum_word;

    `I8DPS_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n, o_adv && i_ctl.last, r_acc == '0)
    `I8DPS_ASSERT_NEXT(a_sum_source, i_clk, i_rst_n, !r_sum_vld && !(o_adv && i_ctl.last), !r_sum_vld)

endmodule

### rtl/core/i8dps_scale.sv
// Scale stage: signed 32 by 32 product of the sum and the column scale into the output register.
`include "int8_dot_product_scale_unit_assert.svh"

module i8dps_scale (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_sum_vld,
    input  i8dps_pkg::t_sum_word    i_sum_word,
    output logic                    o_take,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output i8dps_pkg::t_out_word    o_out_word
);
    import i8dps_pkg::*;

    logic                    r_out_vld;
    logic                    n_out_vld;
    logic                    w_load;
    logic signed [OUT_W-1:0] w_prod;
    t_out_word               r_out_word;

    assign w_prod = i_sum_word.dot * i_sum_word.scale;
    assign w_load = !r_out_vld || i_out_ready;
    assign o_take = i_sum_vld && w_load;

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out_vld = i_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_word.dot_sum      <= i_sum_word.dot;
            r_out_word.scaled_value <= w_prod;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    `I8DPS_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, o_take, r_out_vld)
    `I8DPS_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, r_out_vld && !i_out_ready, r_out_vld)

endmodule

### rtl/core/int8_dot_product_scale_unit.sv
// Top level of the int8 dot product unit with Q16.16 column scaling.
//
//   Channel   Direction  Handshake                   Word
//   in        input      i_in_valid / o_in_ready     t_in_word  (four int8 pairs, count, scale, last)
//   out       output     o_out_valid / i_out_ready   t_out_word (dot_sum, scaled_value)
//
// One word is taken per cycle when the pipeline is not held up.
// A taken last word's result passes the lane product registers, the accumulation into the held sum,
// then the 32 by 32 scale multiplier feeding the output register.
// Reset clears the accumulator and all valid flags; the unit is ready in the next cycle.
// While a result waits in the output register, non-last words keep accumulating;
// a last word waits only when both the output register and the held sum are occupied.
`include "int8_dot_product_scale_unit_assert.svh"

module int8_dot_product_scale_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  i8dps_pkg::t_in_word    i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output i8dps_pkg::t_out_word   o_out_word
);
    import i8dps_pkg::*;

    logic signed [ACT_W-1:0]   w_act [PHYS_LANES];
    logic signed [ACT_W-1:0]   w_wgt [PHYS_LANES];
    logic [PHYS_LANES-1:0]     w_en;
    logic [CNT_W-1:0]          w_cnt;
    logic                      w_accept;
    logic                      w_adv;
    logic                      w_sum_vld;
    logic                      w_take;
    t_sum_word                 w_sum_word;
    t_prod_vec                 w_prods;
    t_stage_ctl                r_ctl;
    t_stage_ctl                n_ctl;
    logic signed [SCALE_W-1:0] r_scale;

    assign w_act[0] = i_in_word.act0;
    assign w_act[1] = i_in_word.act1;
    assign w_act[2] = i_in_word.act2;
    assign w_act[3] = i_in_word.act3;
    assign w_wgt[0] = i_in_word.wgt0;
    assign w_wgt[1] = i_in_word.wgt1;
    assign w_wgt[2] = i_in_word.wgt2;
    assign w_wgt[3] = i_in_word.wgt3;

    assign w_cnt = (i_in_word.lane_count > CNT_W'(LANE_LIM)) ? CNT_W'(LANE_LIM)
                                                              : i_in_word.lane_count;

    assign o_in_ready = !r_ctl.vld || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    for (genvar g = 0; g < PHYS_LANES; g++) begin : g_lane
        logic signed [PROD_W-1:0] w_lane_prod;

        assign w_en[g] = CNT_W'(g) < w_cnt;

        i8dps_lane u_lane (
            .i_clk  (i_clk),
            .i_load (w_accept),
            .i_en   (w_en[g]),
            .i_act  (w_act[g]),
            .i_wgt  (w_wgt[g]),
            .o_prod (w_lane_prod)
        );

        assign w_prods[g] = w_lane_prod;
    end

    always_comb begin
        n_ctl = r_ctl;
        if (w_accept) begin
            n_ctl.vld  = 1'b1;
            n_ctl.last = i_in_word.last;
        end else if (w_adv) begin
            n_ctl.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scale <= i_in_word.col_scale;
        end
    end

    i8dps_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl),
        .i_prods    (w_prods),
        .i_scale    (r_scale),
        .i_take     (w_take),
        .o_adv      (w_adv),
        .o_sum_vld  (w_sum_vld),
        .o_sum_word (w_sum_word)
    );

    i8dps_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sum_vld   (w_sum_vld),
        .i_sum_word  (w_sum_word),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    `I8DPS_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_ctl.vld)
    `I8DPS_ASSERT_IMPLY(a_adv_needs_word, i_clk, i_rst_n, w_adv, r_ctl.vld)

endmodule
